/* rtl/core/pmh64_pkg.sv */
// ----------------------------------------------------------------------------
// pmh64_pkg
// Shared types, constants and helpers of the 64-bit password mix hash core.
// ----------------------------------------------------------------------------
package pmh64_pkg;

    // polynomial modulus and running-power base
    localparam logic [29:0] MOD_P      = 30'd1000000007;
    localparam logic [5:0]  POLY_BASE  = 6'd31;

    // reduction datapath width and helper constants
    localparam int          RED_W      = 41;
    localparam logic [40:0] MOD_2P64   = 41'd582344008;     // 2^64 mod p
    localparam logic [40:0] MOD_BIAS   = 41'd275000001925;  // 275 * p, lifts terms positive
    localparam int          RED_TOP    = 11;                // highest divisor shift

    // mix word constants
    localparam logic [63:0] SALT_RESET = 64'd3735928559;
    localparam logic [63:0] LCG_MUL    = 64'd6364136223846793005;
    localparam logic [63:0] LCG_ADD    = 64'd1442695040888963407;
    localparam logic [31:0] FINAL_MUL  = 32'd2654435761;

    // byte offset applied to the polynomial term
    localparam logic signed [8:0] TERM_OFS = 9'sd96;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_RED1,
        ST_RED2,
        ST_RED3,
        ST_RED4,
        ST_FIN1,
        ST_FIN2,
        ST_OUT
    } pmh64_state_t;

    // shared multiplier operand pairs
    typedef enum logic [2:0] {
        MUL_MIX_LL,
        MUL_MIX_HL,
        MUL_MIX_LH,
        MUL_FIN_L,
        MUL_FIN_H
    } pmh64_mul_sel_t;

    // accumulator operation
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD_HI
    } pmh64_acc_op_t;

    typedef struct packed {
        logic           accept;     // input transfer this cycle
        logic           prep;       // load reduction operands
        logic           red_step;   // three restoring subtract steps
        logic           lcg_done;   // write back mix word
        logic           poly_done;  // write back sum and power
        pmh64_mul_sel_t mul_sel;
        pmh64_acc_op_t  acc_op;
        logic           out_load;   // digest into output register
    } pmh64_cmd_t;

    typedef struct packed {
        logic last;       // current byte ends the message
        logic out_free;   // output register can take a digest
    } pmh64_sts_t;

    // three compare-subtract steps against d, d/2, d/4
    function automatic logic [RED_W-1:0] red_sub3(input logic [RED_W-1:0] x,
                                                  input logic [RED_W-1:0] d);
        logic [RED_W-1:0] r;
        logic [RED_W-1:0] dj;
        r = x;
        for (int j = 0; j < 3; j++) begin
            dj = d >> j;
            if (r >= dj) begin
                r = r - dj;
            end
        end
        return r;
    endfunction

endpackage

/* rtl/core/password_mix_hash64_core.sv */
// ----------------------------------------------------------------------------
// password_mix_hash64_core
// Streaming 64-bit password mix hash: one byte per transfer, one digest per
// message after the byte marked with tlast.
// ----------------------------------------------------------------------------
// Each byte passes through an accept state, an operand state and four
// reduction states before the next byte can be taken. The pace is set by the
// restoring reduction modulo p, which retires three quotient bits a cycle,
// and by the single shared 32x32 multiplier that builds the 64-bit mix product
// from three partial products in the operand and first two reduction states.
// The last byte of a message adds two multiplier passes for the digest and the
// load of the output register, and that load waits while the register is full.
// Bytes of the next message keep flowing while a digest waits there.
// The salt is loaded into the mix word at the first byte of each message.
module password_mix_hash64_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: salt
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    // digest stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [63:0] digest
);
    import pmh64_pkg::*;

    pmh64_cmd_t cmd;
    pmh64_sts_t sts;

    // sequencer
    pmh64_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    pmh64_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

/* rtl/core/pmh64_ctrl.sv */
// ----------------------------------------------------------------------------
// pmh64_ctrl
// Sequencer of the hash core: steps each byte through operand prep, the
// shared multiplier and the modular reduction, then the final digest.
// ----------------------------------------------------------------------------
module pmh64_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  pmh64_pkg::pmh64_sts_t sts,
    output pmh64_pkg::pmh64_cmd_t cmd
);
    import pmh64_pkg::*;

    pmh64_state_t state_reg;
    pmh64_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: state_next = ST_RED1;
            ST_RED1: state_next = ST_RED2;
            ST_RED2: state_next = ST_RED3;
            ST_RED3: state_next = ST_RED4;
            ST_RED4: state_next = sts.last ? ST_FIN1 : ST_IDLE;
            ST_FIN1: state_next = ST_FIN2;
            ST_FIN2: state_next = ST_OUT;
            ST_OUT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd           = '0;
        cmd.mul_sel   = MUL_MIX_LL;
        cmd.acc_op    = ACC_HOLD;
        s_tready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_PREP: begin
                cmd.prep    = 1'b1;
                cmd.mul_sel = MUL_MIX_LL;
                cmd.acc_op  = ACC_LOAD;
            end
            ST_RED1: begin
                cmd.red_step = 1'b1;
                cmd.mul_sel  = MUL_MIX_HL;
                cmd.acc_op   = ACC_ADD_HI;
            end
            ST_RED2: begin
                cmd.red_step = 1'b1;
                cmd.mul_sel  = MUL_MIX_LH;
                cmd.acc_op   = ACC_ADD_HI;
            end
            ST_RED3: begin
                cmd.red_step = 1'b1;
                cmd.lcg_done = 1'b1;
            end
            ST_RED4: begin
                cmd.red_step  = 1'b1;
                cmd.poly_done = 1'b1;
            end
            ST_FIN1: begin
                cmd.mul_sel = MUL_FIN_L;
                cmd.acc_op  = ACC_LOAD;
            end
            ST_FIN2: begin
                cmd.mul_sel = MUL_FIN_H;
                cmd.acc_op  = ACC_ADD_HI;
            end
            ST_OUT: begin
                cmd.out_load = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/core/pmh64_dp.sv */
// ----------------------------------------------------------------------------
// pmh64_dp
// Datapath of the hash core: salt register, polynomial sum and power with
// restoring reduction modulo p, mix word with a shared 32x32 multiplier,
// and the output register.
// ----------------------------------------------------------------------------
module pmh64_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [63:0]           cfg_wr_data,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tlast,
    input  pmh64_pkg::pmh64_cmd_t cmd,
    output pmh64_pkg::pmh64_sts_t sts,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata
);
    import pmh64_pkg::*;

    logic [63:0]      salt_reg;
    logic             in_msg_reg;
    logic [29:0]      sum_reg;
    logic [29:0]      power_reg;
    logic [2:0]       slot_reg;
    logic [63:0]      mix_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic [RED_W-1:0] red_a_reg;
    logic [RED_W-1:0] red_b_reg;
    logic [RED_W-1:0] div_reg;
    logic [63:0]      acc_reg;
    logic             out_valid_reg;
    logic [63:0]      out_data_reg;

    logic [63:0]        sext64;
    logic [63:0]        mix_xor;
    logic signed [8:0]  coef;
    logic signed [30:0] pw_s;
    logic signed [39:0] term;
    logic signed [40:0] sum_v;
    logic signed [40:0] sum_w;
    logic [RED_W-1:0]   red_a_init;
    logic [RED_W-1:0]   red_b_init;
    logic [RED_W-1:0]   red_a_next;
    logic [RED_W-1:0]   red_b_next;
    logic [63:0]        comb_word;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_p;
    logic [63:0]        acc_next;
    logic               out_free;

    // salt register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            salt_reg <= SALT_RESET;
        end else if (cfg_wr_en) begin
            salt_reg <= cfg_wr_data;
        end
    end

    // byte xored into the mix word at its slot
    assign sext64  = {{56{s_tdata[7]}}, s_tdata};
    assign mix_xor = (in_msg_reg ? mix_reg : salt_reg) ^ (sext64 << {slot_reg, 3'b000});

    // polynomial term, lifted into a positive range congruent mod p
    assign coef  = $signed({byte_reg[7], byte_reg}) - TERM_OFS;
    assign pw_s  = $signed({1'b0, power_reg});
    assign term  = 40'(coef) * 40'(pw_s);
    assign sum_v = $signed({11'b0, sum_reg}) + 41'(term);
    assign sum_w = sum_v[40] ? (sum_v + $signed(MOD_2P64)) : sum_v;
    assign red_a_init = $unsigned(sum_w) + MOD_BIAS;
    assign red_b_init = ({11'b0, power_reg} << 5) - {11'b0, power_reg};

    // restoring reduction steps
    assign red_a_next = red_sub3(red_a_reg, div_reg);
    assign red_b_next = red_sub3(red_b_reg, div_reg);

    // value fed to the final multiply
    assign comb_word = {34'b0, sum_reg} ^ {16'b0, mix_reg[63:16]};

    // shared multiplier operand select
    always_comb begin
        mul_a = mix_reg[31:0];
        mul_b = LCG_MUL[31:0];
        case (cmd.mul_sel)
            MUL_MIX_LL: begin
                mul_a = mix_reg[31:0];
                mul_b = LCG_MUL[31:0];
            end
            MUL_MIX_HL: begin
                mul_a = mix_reg[63:32];
                mul_b = LCG_MUL[31:0];
            end
            MUL_MIX_LH: begin
                mul_a = mix_reg[31:0];
                mul_b = LCG_MUL[63:32];
            end
            MUL_FIN_L: begin
                mul_a = comb_word[31:0];
                mul_b = FINAL_MUL;
            end
            MUL_FIN_H: begin
                mul_a = comb_word[63:32];
                mul_b = FINAL_MUL;
            end
            default: begin
                mul_a = mix_reg[31:0];
                mul_b = LCG_MUL[31:0];
            end
        endcase
    end

    assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

    // accumulator of partial products, low 64 bits kept
    always_comb begin
        acc_next = acc_reg;
        case (cmd.acc_op)
            ACC_HOLD:   acc_next = acc_reg;
            ACC_LOAD:   acc_next = mul_p;
            ACC_ADD_HI: acc_next = acc_reg + {mul_p[31:0], 32'b0};
            default:    acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // message state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_msg_reg <= 1'b0;
            sum_reg    <= '0;
            power_reg  <= 30'd1;
            slot_reg   <= '0;
        end else if (cmd.out_load) begin
            in_msg_reg <= 1'b0;
            sum_reg    <= '0;
            power_reg  <= 30'd1;
            slot_reg   <= '0;
        end else begin
            if (cmd.accept) begin
                in_msg_reg <= 1'b1;
            end
            if (cmd.poly_done) begin
                sum_reg   <= red_a_next[29:0];
                power_reg <= red_b_next[29:0];
                slot_reg  <= slot_reg + 3'd1;
            end
        end
    end

    // byte, mix word and reduction registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
            mix_reg  <= mix_xor;
        end else if (cmd.lcg_done) begin
            mix_reg  <= acc_reg + LCG_ADD;
        end
        if (cmd.prep) begin
            red_a_reg <= red_a_init;
            red_b_reg <= red_b_init;
            div_reg   <= {11'b0, MOD_P} << RED_TOP;
        end else if (cmd.red_step) begin
            red_a_reg <= red_a_next;
            red_b_reg <= red_b_next;
            div_reg   <= div_reg >> 3;
        end
    end

    // output register
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= acc_reg;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;
    assign sts.last     = last_reg;
    assign sts.out_free = out_free;

endmodule
